>>> hdl/ipv4_header_parse_check_assert.svh
// Assertion macros for the IPv4 header parser RTL.
`ifndef IPV4_HEADER_PARSE_CHECK_ASSERT_SVH
`define IPV4_HEADER_PARSE_CHECK_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define IPHC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define IPHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/iphc_pkg.sv
// Types and constants for the IPv4 header parser.
package iphc_pkg;

	localparam int HdrBytes  = 20;
	localparam int CountW    = 6;
	localparam int MaxCount  = 60;
	localparam int SumW      = 20;
	localparam int ChkLoIdx  = 11;
	localparam int ChkHiIdx  = 10;
	localparam int IpVersion = 4;
	localparam int MinWords  = 5;

	// flags/offset word bits
	localparam int DfBit = 14;
	localparam int MfBit = 13;
	localparam logic [15:0] FragMask = 16'h1fff;

	typedef logic [7:0] byte_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_TRUNC  = 3'd1,
		ST_BADVER = 3'd2,
		ST_BADLEN = 3'd3,
		ST_BADSUM = 3'd4
	} status_t;

	typedef struct packed {
		status_t      status;
		logic [3:0]   header_words;
		logic [7:0]   service_type;
		logic [15:0]  total_length;
		logic [15:0]  ident;
		logic         dont_fragment;
		logic         more_fragments;
		logic [12:0]  fragment_offset;
		logic [7:0]   time_to_live;
		logic [7:0]   protocol;
		logic [31:0]  source_addr;
		logic [31:0]  dest_addr;
	} result_t;

	// control from the byte stage to the checksum unit
	typedef struct packed {
		logic step;
		logic restart;
		logic add_en;
	} csum_ctl_t;

endpackage

>>> hdl/iphc_byte_if.sv
// Byte stream channel: one packet byte per transaction.
interface iphc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_flag;
	logic       end_flag;

	modport source (output valid, data_byte, start_flag, end_flag, input ready);
	modport sink (input valid, data_byte, start_flag, end_flag, output ready);
endinterface

>>> hdl/iphc_result_if.sv
// Result channel: parsed header fields and status, one per packet.
interface iphc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  header_words;
	logic [7:0]  service_type;
	logic [15:0] total_length;
	logic [15:0] ident;
	logic        dont_fragment;
	logic        more_fragments;
	logic [12:0] fragment_offset;
	logic [7:0]  time_to_live;
	logic [7:0]  protocol;
	logic [31:0] source_addr;
	logic [31:0] dest_addr;

	modport source (output valid, status, header_words, service_type, total_length, ident,
		dont_fragment, more_fragments, fragment_offset, time_to_live, protocol,
		source_addr, dest_addr, input ready);
	modport sink (input valid, status, header_words, service_type, total_length, ident,
		dont_fragment, more_fragments, fragment_offset, time_to_live, protocol,
		source_addr, dest_addr, output ready);
endinterface

>>> hdl/iphc_csum.sv
// Header checksum accumulator with fold and compare.
module iphc_csum (
	input  logic               clk,
	input  logic               arst_n,
	input  iphc_pkg::csum_ctl_t ctl,
	input  logic [15:0]        word,
	input  logic [15:0]        given,
	output logic               match
);

	logic [iphc_pkg::SumW-1:0] sum_q;
	logic [iphc_pkg::SumW-1:0] sum_base;
	logic [iphc_pkg::SumW-1:0] sum_nx;
	logic [16:0]               fold1;
	logic [16:0]               fold2;

	always_comb begin
		sum_base = ctl.restart ? '0 : sum_q;
		sum_nx   = sum_base + (ctl.add_en ? {{(iphc_pkg::SumW-16){1'b0}}, word} : '0);
		// fold carries twice into the low 16 bits
		fold1 = {1'b0, sum_nx[15:0]} + {{(17-(iphc_pkg::SumW-16)){1'b0}},
			sum_nx[iphc_pkg::SumW-1:16]};
		fold2 = {1'b0, fold1[15:0]} + {16'b0, fold1[16]};
		match = (~fold2[15:0]) == given;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.step) begin
			sum_q <= sum_nx;
		end
	end

endmodule

>>> hdl/ipv4_header_parse_check.sv
// IPv4 header parser and checker, one packet byte per transaction.
// Throughput: one byte per cycle unless stalled; the checksum add/fold is combinational.
// A result goes into the output register from the input-stage byte that completes it.
// A full output register stalls input only when the buffered byte produces a result.
// Reset clears the stage valids, parse state, byte counter and checksum sum;
// captured header bytes are not reset.
`include "ipv4_header_parse_check_assert.svh"

module ipv4_header_parse_check (
	input  logic          clk,
	input  logic          arst_n,
	iphc_byte_if.sink     pkt,
	iphc_result_if.source res
);

	localparam logic [iphc_pkg::CountW-1:0] HdrCnt = iphc_pkg::CountW'(iphc_pkg::HdrBytes);
	localparam logic [iphc_pkg::CountW-1:0] MaxCnt = iphc_pkg::CountW'(iphc_pkg::MaxCount);
	localparam logic [iphc_pkg::CountW-1:0] ChkLo  = iphc_pkg::CountW'(iphc_pkg::ChkLoIdx);

	// input stage
	logic                s1_valid;
	iphc_pkg::byte_t     s1_byte;
	logic                s1_start;
	logic                s1_end;

	// parse state
	logic                          active_q;
	logic [iphc_pkg::CountW-1:0]   cnt_q;
	iphc_pkg::byte_t               hdr_q [iphc_pkg::HdrBytes];
	iphc_pkg::byte_t               prev_q;

	// result register
	logic                res_valid_q;
	iphc_pkg::result_t   res_q;

	logic                          active_c;
	logic [iphc_pkg::CountW-1:0]   cnt_c;
	logic [iphc_pkg::CountW-1:0]   cnt_nx;
	logic                          in_hdr;
	iphc_pkg::byte_t               hdr_nx [iphc_pkg::HdrBytes];
	logic [3:0]                    ver;
	logic [3:0]                    words;
	logic [iphc_pkg::CountW-1:0]   need;
	logic                          emit;
	logic                          zero_fields;
	iphc_pkg::status_t             status_c;
	iphc_pkg::result_t             res_c;
	logic                          out_free;
	logic                          s1_go;
	logic                          sum_match;
	iphc_pkg::csum_ctl_t           csum_ctl;
	logic [15:0]                   flags_off;

	always_comb begin
		active_c = s1_start | active_q;
		cnt_c    = s1_start ? '0 : cnt_q;
		in_hdr   = cnt_c < HdrCnt;
		cnt_nx   = (cnt_c < MaxCnt) ? cnt_c + 1'b1 : cnt_c;
		for (int k = 0; k < iphc_pkg::HdrBytes; k++) begin
			hdr_nx[k] = (active_c && in_hdr && cnt_c == iphc_pkg::CountW'(k)) ?
				s1_byte : hdr_q[k];
		end
		ver   = hdr_nx[0][7:4];
		words = hdr_nx[0][3:0];
		need  = {words, 2'b00};
	end

	// sum each odd header byte with its predecessor, skipping the checksum word
	assign csum_ctl.step    = s1_go && active_c;
	assign csum_ctl.restart = s1_start;
	assign csum_ctl.add_en  = active_c && in_hdr && cnt_c[0] && (cnt_c != ChkLo);

	iphc_csum u_csum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (csum_ctl),
		.word   ({prev_q, s1_byte}),
		.given  ({hdr_nx[iphc_pkg::ChkHiIdx], hdr_nx[iphc_pkg::ChkLoIdx]}),
		.match  (sum_match)
	);

	always_comb begin
		emit        = 1'b0;
		zero_fields = 1'b0;
		status_c    = iphc_pkg::ST_OK;
		if (!s1_valid || !active_c) begin
			emit = 1'b0;
		end else if (cnt_nx < HdrCnt) begin
			emit        = s1_end;
			zero_fields = 1'b1;
			status_c    = iphc_pkg::ST_TRUNC;
		end else if (cnt_nx == HdrCnt && ver != 4'(iphc_pkg::IpVersion)) begin
			emit     = 1'b1;
			status_c = iphc_pkg::ST_BADVER;
		end else if (cnt_nx == HdrCnt && words < 4'(iphc_pkg::MinWords)) begin
			emit     = 1'b1;
			status_c = iphc_pkg::ST_BADLEN;
		end else if (cnt_nx >= need) begin
			emit     = 1'b1;
			status_c = sum_match ? iphc_pkg::ST_OK : iphc_pkg::ST_BADSUM;
		end else if (s1_end) begin
			emit     = 1'b1;
			status_c = iphc_pkg::ST_TRUNC;
		end
	end

	always_comb begin
		flags_off = {hdr_nx[6], hdr_nx[7]};
		res_c.status          = status_c;
		res_c.header_words    = hdr_nx[0][3:0];
		res_c.service_type    = hdr_nx[1];
		res_c.total_length    = {hdr_nx[2], hdr_nx[3]};
		res_c.ident           = {hdr_nx[4], hdr_nx[5]};
		res_c.dont_fragment   = flags_off[iphc_pkg::DfBit];
		res_c.more_fragments  = flags_off[iphc_pkg::MfBit];
		res_c.fragment_offset = 13'(flags_off & iphc_pkg::FragMask);
		res_c.time_to_live    = hdr_nx[8];
		res_c.protocol        = hdr_nx[9];
		res_c.source_addr     = {hdr_nx[12], hdr_nx[13], hdr_nx[14], hdr_nx[15]};
		res_c.dest_addr       = {hdr_nx[16], hdr_nx[17], hdr_nx[18], hdr_nx[19]};
		// short packet: report status only
		if (zero_fields) begin
			res_c        = '0;
			res_c.status = iphc_pkg::ST_TRUNC;
		end
	end

	assign out_free  = !res_valid_q || res.ready;
	assign s1_go     = s1_valid && (!emit || out_free);
	assign pkt.ready = !s1_valid || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			active_q    <= 1'b0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pkt.ready) begin
				s1_valid <= pkt.valid;
			end
			if (s1_go && active_c) begin
				active_q <= !emit;
				cnt_q    <= cnt_nx;
			end
			if (s1_go && emit) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			s1_byte  <= pkt.data_byte;
			s1_start <= pkt.start_flag;
			s1_end   <= pkt.end_flag;
		end
		if (s1_go) begin
			hdr_q  <= hdr_nx;
			prev_q <= s1_byte;
		end
		if (s1_go && emit) begin
			res_q <= res_c;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.status          = res_q.status;
	assign res.header_words    = res_q.header_words;
	assign res.service_type    = res_q.service_type;
	assign res.total_length    = res_q.total_length;
	assign res.ident           = res_q.ident;
	assign res.dont_fragment   = res_q.dont_fragment;
	assign res.more_fragments  = res_q.more_fragments;
	assign res.fragment_offset = res_q.fragment_offset;
	assign res.time_to_live    = res_q.time_to_live;
	assign res.protocol        = res_q.protocol;
	assign res.source_addr     = res_q.source_addr;
	assign res.dest_addr       = res_q.dest_addr;

	`IPHC_ASSERT_NEXT(a_result_ends_parse, s1_go && emit, !active_q,
		"parse still active after its result")
	`IPHC_ASSERT_NEXT(a_stall_holds_byte, s1_valid && emit && res_valid_q && !res.ready,
		s1_valid, "byte with a pending result dropped during output stall")
	`IPHC_ASSERT_NOW(a_header_sane_past_20, active_q && cnt_q >= HdrCnt,
		hdr_q[0][7:4] == 4'(iphc_pkg::IpVersion) && hdr_q[0][3:0] >= 4'(iphc_pkg::MinWords),
		"parse continued past fixed header with bad version or length")

endmodule
